// File: sv/hard_disk_trial_move_assert.svh
// ----------------------------------------------------------------------------
// Hard-disk trial move: assertion macros
// Shorthand for clocked implications, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef HARD_DISK_TRIAL_MOVE_ASSERT_SVH
`define HARD_DISK_TRIAL_MOVE_ASSERT_SVH

// Same-cycle implication.
`define HDTM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HDTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/hdtm_pkg.sv
// ----------------------------------------------------------------------------
// Hard-disk trial move: shared package
// Widths, codes, memory request types and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package hdtm_pkg;

	localparam int FRACTION_BITS = 14;
	localparam int POS_W         = 24;
	localparam int DISC_W        = 16;
	localparam int TILE_W        = 18;
	localparam int COORD_W       = 9;
	localparam int CFG_W         = 10;
	localparam int MAX_ROW       = 512;
	localparam int GRID_DEPTH    = MAX_ROW * MAX_ROW;
	localparam int DISC_DEPTH    = 65536;

	localparam logic [23:0] SCALE_Q24 = 24'd11863283;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_MOVE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	typedef struct packed {
		logic [TILE_W-1:0] tile;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  x;
	} disc_word_t;

	typedef struct packed {
		logic              valid;
		logic [DISC_W-1:0] idx;
	} grid_word_t;

	typedef struct packed {
		logic              we;
		logic [DISC_W-1:0] addr;
		disc_word_t        wdata;
	} disc_req_t;

	typedef struct packed {
		logic              we;
		logic [TILE_W-1:0] addr;
		grid_word_t        wdata;
	} grid_req_t;

	// Wrap once into [0, b], then clamp.
	function automatic logic [POS_W-1:0] reduce_coord(input logic signed [26:0] v,
		input logic [POS_W-1:0] b);
		logic signed [26:0] bs;
		logic signed [26:0] w;
		bs = signed'({3'b000, b});
		if (v < 0) begin
			w = v + bs;
		end else if (v > bs) begin
			w = v - bs;
		end else begin
			w = v;
		end
		if (w < 0) begin
			return '0;
		end else if (w > bs) begin
			return b;
		end
		return w[POS_W-1:0];
	endfunction

	// Tiles per row limited to [3, MAX_ROW].
	function automatic logic [CFG_W-1:0] rows_eff(input logic [CFG_W-1:0] t);
		if (t < CFG_W'(3)) begin
			return CFG_W'(3);
		end else if (t > CFG_W'(MAX_ROW)) begin
			return CFG_W'(MAX_ROW);
		end
		return t;
	endfunction

endpackage

`default_nettype wire

// File: sv/hdtm_disc_mem.sv
// ----------------------------------------------------------------------------
// Hard-disk trial move: disc memory
// Position and tile of every disc, one port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hdtm_disc_mem (
	input  wire logic                clk,
	input  wire hdtm_pkg::disc_req_t req,
	output hdtm_pkg::disc_word_t     rdata
);
	import hdtm_pkg::*;

	disc_word_t mem [DISC_DEPTH];
	disc_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/hdtm_grid_mem.sv
// ----------------------------------------------------------------------------
// Hard-disk trial move: tile grid memory
// Occupant of every tile; swept to empty after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hdtm_grid_mem (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hdtm_pkg::grid_req_t req,
	output hdtm_pkg::grid_word_t     rdata,
	output logic                     busy
);
	import hdtm_pkg::*;

	grid_word_t        mem [GRID_DEPTH];
	grid_word_t        rdata_q;
	logic [TILE_W-1:0] clr_q;
	logic              busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + TILE_W'(1);
			if (&clr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= '0;
		end else if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

`default_nettype wire

// File: sv/hard_disk_trial_move.sv
// ----------------------------------------------------------------------------
// Hard-disk trial move engine
// Loads, moves and reads unit discs in a periodic box with a tile grid.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Words
// s_*       in   kind in tuser; disc index and x/y value in tdata
// m_*       out  accepted flag, position, tile and the two totals
// apb       in   box_side at 0x0, tiles_per_row at 0x4
//
// A load reduces the x/y value into the box, finds its tile and writes both
// memories; a read returns the stored disc. A move adds the step, finds the
// new tile and scans the 25 tiles around it: a grid memory read per tile and,
// for a tile held by another disc, a dependent disc memory read and distance
// check. A hit rejects the move, else the old tile is cleared and the new one
// written. After reset the grid memory is swept to empty, during which
// no word is taken on the input; configuration writes are taken at any time.
// One word is worked on at a time; a finished result waits in the output
// register while the next word is taken, and stalls the engine only if a
// second result is ready before the first has left.
`default_nettype none

module hard_disk_trial_move (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// APB configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	// input words
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [71:0]  s_tdata,  // disc_index[15:0], value_x[40:16], value_y[65:41]
	input  wire logic [1:0]   s_tuser,  // kind[1:0]
	// result words
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [135:0] m_tdata   // accepted[0], disc_x[24:1], disc_y[48:25],
	                                    // disc_tile[66:49], accept_total[98:67],
	                                    // reject_total[130:99]
);
	import hdtm_pkg::*;

	`include "hard_disk_trial_move_assert.svh"

	typedef enum logic [4:0] {
		S_IDLE, S_LD_RED, S_MV_RD, S_MV_RED, S_RD_CAP,
		S_TILE_MUL, S_TILE_ADDR, S_TILE_SUM, S_LD_WR,
		S_SC_ADDR, S_SC_GRD, S_SC_GWAIT, S_SC_DWAIT, S_SC_SQ, S_SC_CMP,
		S_OLD_RD, S_OLD_CHK, S_NEW_WR, S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CFG_W-1:0] box_q;
	logic [CFG_W-1:0] rows_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? {22'd0, rows_q} : {22'd0, box_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q  <= CFG_W'(500);
			rows_q <= CFG_W'(354);
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				rows_q <= pwdata[CFG_W-1:0];
			end else begin
				box_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	logic [POS_W-1:0] box_len;
	logic [CFG_W-1:0] row_len;
	assign box_len = {box_q, FRACTION_BITS'(0)};
	assign row_len = rows_eff(rows_q);

	// memories
	disc_req_t  disc_req;
	disc_word_t disc_rdata;
	grid_req_t  grid_req;
	grid_word_t grid_rdata;
	logic       grid_busy;

	hdtm_disc_mem u_disc (
		.clk   (clk),
		.req   (disc_req),
		.rdata (disc_rdata)
	);

	hdtm_grid_mem u_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (grid_req),
		.rdata  (grid_rdata),
		.busy   (grid_busy)
	);

	// working registers
	logic [1:0]               kind_q;
	logic [DISC_W-1:0]        d_q;
	logic signed [24:0]       vx_q, vy_q;
	disc_word_t               old_q;
	logic [POS_W-1:0]         nx_q, ny_q;
	logic [47:0]              prodx_q, prody_q;
	logic [COORD_W-1:0]       ix_q, iy_q;
	logic [TILE_W-1:0]        tnew_q;
	logic [2:0]               di_q, dj_q;
	logic [TILE_W-1:0]        scan_addr_q;
	logic signed [26:0]       jx_q, jy_q;
	logic [14:0]              ax_q, ay_q;
	logic                     far_q;
	logic [29:0]              sqx_q, sqy_q;
	logic [31:0]              acc_total_q, rej_total_q;
	logic                     res_ok_q;
	disc_word_t               res_q;
	logic                     out_ok_q;
	disc_word_t               out_q;
	logic [31:0]              out_acc_q, out_rej_q;

	assign s_tready = (state_q == S_IDLE) && !grid_busy;
	assign m_tdata  = {5'd0, out_rej_q, out_acc_q, out_q.tile, out_q.y, out_q.x, out_ok_q};

	// tile coordinate clamp
	logic [9:0] tx_raw, ty_raw;
	logic [9:0] row_last;
	assign tx_raw   = prodx_q[47:38];
	assign ty_raw   = prody_q[47:38];
	assign row_last = row_len - 10'd1;

	// scan neighbour tile with periodic shift
	logic signed [10:0] lsig, cs, rs;
	logic [COORD_W-1:0] col, row;
	logic signed [26:0] jx_n, jy_n, bsig;
	logic [18:0]        sc_addr;

	always_comb begin
		lsig = signed'({1'b0, row_len});
		bsig = signed'({3'b000, box_len});
		cs   = signed'({2'b00, ix_q}) + signed'({8'd0, di_q}) - 11'sd2;
		rs   = signed'({2'b00, iy_q}) + signed'({8'd0, dj_q}) - 11'sd2;
		col  = cs[COORD_W-1:0];
		jx_n = '0;
		if (cs < 0) begin
			col  = COORD_W'(cs + lsig);
			jx_n = -bsig;
		end else if (cs > lsig - 11'sd1) begin
			col  = COORD_W'(cs - lsig);
			jx_n = bsig;
		end
		row  = rs[COORD_W-1:0];
		jy_n = '0;
		if (rs < 0) begin
			row  = COORD_W'(rs + lsig);
			jy_n = -bsig;
		end else if (rs > lsig - 11'sd1) begin
			row  = COORD_W'(rs - lsig);
			jy_n = bsig;
		end
		sc_addr = {10'd0, col} + row_len * row;
	end

	// distance to a candidate disc
	logic signed [26:0] dx, dy;
	logic [26:0]        adx, ady;
	always_comb begin
		dx  = signed'({3'b000, disc_rdata.x}) + jx_q - signed'({3'b000, nx_q});
		dy  = signed'({3'b000, disc_rdata.y}) + jy_q - signed'({3'b000, ny_q});
		adx = (dx < 0) ? 27'(-dx) : 27'(dx);
		ady = (dy < 0) ? 27'(-dy) : 27'(dy);
	end

	logic scan_last;
	assign scan_last = (di_q == 3'd4) && (dj_q == 3'd4);

	logic hit;
	assign hit = !far_q && ({1'b0, sqx_q} + {1'b0, sqy_q} < 31'h4000_0000);

	// memory requests
	always_comb begin
		disc_req       = '0;
		disc_req.addr  = d_q;
		grid_req       = '0;
		grid_req.addr  = tnew_q;
		unique case (state_q)
			S_SC_GRD: grid_req.addr = scan_addr_q;
			S_SC_GWAIT: disc_req.addr = grid_rdata.idx;
			S_OLD_RD: grid_req.addr = old_q.tile;
			S_OLD_CHK: begin
				grid_req.addr = old_q.tile;
				grid_req.we   = grid_rdata.valid && (grid_rdata.idx == d_q);
			end
			S_LD_WR, S_NEW_WR: begin
				grid_req.we    = 1'b1;
				grid_req.wdata = '{valid: 1'b1, idx: d_q};
				disc_req.we    = 1'b1;
				disc_req.wdata = '{tile: tnew_q, y: ny_q, x: nx_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			m_tvalid    <= 1'b0;
			acc_total_q <= '0;
			rej_total_q <= '0;
			di_q        <= '0;
			dj_q        <= '0;
		end else begin
			// In S_DONE the output register is reloaded below instead.
			if (m_tvalid && m_tready && (state_q != S_DONE)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						kind_q <= s_tuser;
						d_q    <= s_tdata[15:0];
						vx_q   <= s_tdata[40:16];
						vy_q   <= s_tdata[65:41];
						unique case (s_tuser)
							KIND_LOAD: state_q <= S_LD_RED;
							KIND_MOVE, KIND_READ: state_q <= S_MV_RD;
							KIND_NONE: begin
								res_ok_q <= 1'b0;
								res_q    <= '0;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_LD_RED: begin
					nx_q    <= reduce_coord(27'(vx_q), box_len);
					ny_q    <= reduce_coord(27'(vy_q), box_len);
					state_q <= S_TILE_MUL;
				end
				S_MV_RD: begin
					state_q <= (kind_q == KIND_READ) ? S_RD_CAP : S_MV_RED;
				end
				S_RD_CAP: begin
					res_ok_q <= 1'b1;
					res_q    <= disc_rdata;
					state_q  <= S_DONE;
				end
				S_MV_RED: begin
					old_q   <= disc_rdata;
					nx_q    <= reduce_coord(signed'({3'b000, disc_rdata.x}) + 27'(vx_q), box_len);
					ny_q    <= reduce_coord(signed'({3'b000, disc_rdata.y}) + 27'(vy_q), box_len);
					state_q <= S_TILE_MUL;
				end
				S_TILE_MUL: begin
					prodx_q <= nx_q * SCALE_Q24;
					prody_q <= ny_q * SCALE_Q24;
					state_q <= S_TILE_ADDR;
				end
				S_TILE_ADDR: begin
					ix_q    <= COORD_W'((tx_raw > row_last) ? row_last : tx_raw);
					iy_q    <= COORD_W'((ty_raw > row_last) ? row_last : ty_raw);
					state_q <= S_TILE_SUM;
				end
				S_TILE_SUM: begin
					tnew_q  <= TILE_W'({10'd0, ix_q} + row_len * iy_q);
					di_q    <= '0;
					dj_q    <= '0;
					state_q <= (kind_q == KIND_LOAD) ? S_LD_WR : S_SC_ADDR;
				end
				S_LD_WR: begin
					res_ok_q <= 1'b1;
					res_q    <= '{tile: tnew_q, y: ny_q, x: nx_q};
					state_q  <= S_DONE;
				end
				S_SC_ADDR: begin
					scan_addr_q <= sc_addr[TILE_W-1:0];
					jx_q        <= jx_n;
					jy_q        <= jy_n;
					state_q     <= S_SC_GRD;
				end
				S_SC_GRD: begin
					state_q <= S_SC_GWAIT;
				end
				S_SC_GWAIT: begin
					if (grid_rdata.valid && (grid_rdata.idx != d_q)) begin
						state_q <= S_SC_DWAIT;
					end else if (scan_last) begin
						state_q <= S_OLD_RD;
					end else begin
						di_q    <= (di_q == 3'd4) ? 3'd0 : di_q + 3'd1;
						dj_q    <= (di_q == 3'd4) ? dj_q + 3'd1 : dj_q;
						state_q <= S_SC_ADDR;
					end
				end
				S_SC_DWAIT: begin
					far_q   <= (adx >= 27'(2 << FRACTION_BITS)) || (ady >= 27'(2 << FRACTION_BITS));
					ax_q    <= adx[14:0];
					ay_q    <= ady[14:0];
					state_q <= S_SC_SQ;
				end
				S_SC_SQ: begin
					sqx_q   <= ax_q * ax_q;
					sqy_q   <= ay_q * ay_q;
					state_q <= S_SC_CMP;
				end
				S_SC_CMP: begin
					if (hit) begin
						rej_total_q <= rej_total_q + 32'd1;
						res_ok_q    <= 1'b0;
						res_q       <= old_q;
						state_q     <= S_DONE;
					end else if (scan_last) begin
						state_q <= S_OLD_RD;
					end else begin
						di_q    <= (di_q == 3'd4) ? 3'd0 : di_q + 3'd1;
						dj_q    <= (di_q == 3'd4) ? dj_q + 3'd1 : dj_q;
						state_q <= S_SC_ADDR;
					end
				end
				S_OLD_RD: begin
					state_q <= S_OLD_CHK;
				end
				S_OLD_CHK: begin
					state_q <= S_NEW_WR;
				end
				S_NEW_WR: begin
					acc_total_q <= acc_total_q + 32'd1;
					res_ok_q    <= 1'b1;
					res_q       <= '{tile: tnew_q, y: ny_q, x: nx_q};
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid  <= 1'b1;
						out_ok_q  <= res_ok_q;
						out_q     <= res_q;
						out_acc_q <= acc_total_q;
						out_rej_q <= rej_total_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HDTM_ASSERT_IMPL(a_no_take_while_clearing, grid_busy, !s_tready, "word taken during grid sweep")
	`HDTM_ASSERT_IMPL(a_no_write_while_clearing, grid_busy, !grid_req.we, "grid written during sweep")
	`HDTM_ASSERT_NEXT(a_accept_count, state_q == S_NEW_WR,
		acc_total_q == $past(acc_total_q) + 32'd1, "accept total not advanced")
	`HDTM_ASSERT_IMPL(a_scan_range, state_q == S_SC_ADDR,
		(di_q <= 3'd4) && (dj_q <= 3'd4), "scan offset out of range")

endmodule

`default_nettype wire
